[rtl/core/uerc_pkg.sv]
// Shared types, register indexes and constants of the ultrasonic echo ranging controller.
`default_nettype none

package uerc_pkg;

   // Width of the free-running tick counter.
   localparam int COUNTER_BITS = 16;
   // Compare width that holds both the counter and the 16-bit registers.
   localparam int WIDE_BITS = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

   // Ticks that the trigger pin is held low before the high pulse.
   localparam logic [7:0] PRE_TICKS = 8'd2;

   // Reciprocal constants for exact division of a 16-bit width by 58.
   localparam logic [16:0] CM_RECIP = 17'd72316;     // ceil(2^22 / 58)
   localparam int          CM_SHIFT = 22;
   localparam logic [23:0] MM_RECIP = 24'd11570500;  // 10 * ceil(2^26 / 58)
   localparam int          MM_SHIFT = 26;

   // Register reset values.
   localparam logic [15:0] TIMEOUT_RESET   = 16'd30000;
   localparam logic [15:0] TOP_RESET       = 16'd65535;
   localparam logic [7:0]  TRIG_WIDTH_RESET = 8'd10;

   typedef enum logic [1:0] {
      CSR_TIMEOUT    = 2'd0,
      CSR_TOP        = 2'd1,
      CSR_TRIG_WIDTH = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_RISE = 3'd1,
      PH_FALL = 3'd2,
      PH_DONE = 3'd3,
      PH_TOUT = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      TS_OFF  = 2'd0,
      TS_PRE  = 2'd1,
      TS_HIGH = 2'd2
   } trig_stage_type;

   typedef struct packed {
      logic action;
      logic echo_level;
   } req_payload_type;

   typedef struct packed {
      logic        trigger_out;
      logic [2:0]  phase;
      logic        start_refused;
      logic [15:0] echo_ticks;
      logic [13:0] distance_mm;
      logic [10:0] distance_cm;
   } rsp_payload_type;

   // Result of the state update, carried to the distance stage.
   typedef struct packed {
      logic        trigger_out;
      logic [2:0]  phase;
      logic        start_refused;
      logic [15:0] echo_ticks;
   } meas_type;

endpackage

`default_nettype wire

[rtl/core/uerc_distance.sv]
// Converts a measured echo width into millimetres and centimetres by reciprocal multiply.
`default_nettype none

module uerc_distance
   import uerc_pkg::*;
(
   input  wire logic [15:0] echo_ticks,
   output logic      [13:0] distance_mm,
   output logic      [10:0] distance_cm
);

   logic [39:0] mm_prod;
   logic [32:0] cm_prod;

   // The reciprocals are rounded up far enough that the quotients are exact
   // for every 16-bit width.
   always_comb begin
      mm_prod = 40'(echo_ticks) * 40'(MM_RECIP);
      cm_prod = 33'(echo_ticks) * 33'(CM_RECIP);
      distance_mm = 14'(mm_prod >> MM_SHIFT);
      distance_cm = 11'(cm_prod >> CM_SHIFT);
   end

endmodule

`default_nettype wire

[rtl/core/ultrasonic_echo_ranging_controller_top.sv]
// Top level of the ultrasonic echo ranging controller: trigger sequencer, echo timer, output stages.
`default_nettype none

// Each request is either a start command or one microsecond tick with the
// sampled echo pin level, and every request yields exactly one response. A
// start in idle, done or timeout clears the counter and captures and begins
// a trigger sequence (pin low for two ticks, high for trigger_width ticks,
// then low); a start while a measurement is in progress is answered with
// start_refused set and changes nothing. On each tick the counter advances
// and wraps after counter_top, a rising echo edge in wait-rising captures
// the counter, a falling edge in wait-falling computes the pulse width
// (allowing for one wrap) and enters done, and a measurement still in
// progress then times out once the counter reaches timeout_ticks; the
// timeout wins over a rising capture on the same tick. The echo width and
// the distances are reported only when the phase is done, otherwise zero.
// The block takes one request per clock cycle while it is not stalled; the
// state update is registered in a first stage and the divide-by-58
// distance conversion, done by reciprocal multiplication, fills the
// response register. The pipeline stalls as a whole only when both
// stages hold a result and rsp_stall is high. Configuration registers are
// written through csr_we, csr_index and csr_wdata and should only be
// written while the block is idle; indexes beyond the register list are
// ignored.

module ultrasonic_echo_ranging_controller_top
   import uerc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,

   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,

   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload,

   input  wire logic            csr_we,
   input  wire logic [1:0]      csr_index,
   input  wire logic [15:0]     csr_wdata
);

   // Configuration registers.
   logic [15:0] timeout_ff;
   logic [15:0] top_ff;
   logic [7:0]  trig_width_ff;

   // Measurement state.
   phase_type              phase_ff, phase_in;
   logic [COUNTER_BITS-1:0] tick_ff, tick_in;
   logic [15:0]            rise_ff, rise_in;
   logic [15:0]            width_ff, width_in;
   logic                   last_echo_ff, last_echo_in;
   trig_stage_type         tstage_ff, tstage_in;
   logic [7:0]             tcount_ff, tcount_in;

   // First stage: registered state-update result.
   logic     a_valid_ff;
   meas_type a_meas_ff, a_meas_in;

   // Second stage: the response register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   logic req_accept;
   logic b_load;
   logic busy;

   logic [13:0] conv_mm;
   logic [10:0] conv_cm;

   // Handshake: the second stage loads whenever it is empty or being drained,
   // and the first stage takes a request whenever it is empty or empties in the same edge.
   assign b_load     = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = a_valid_ff && !b_load;
   assign req_accept = req_valid && !req_stall;

   assign busy = (phase_ff == PH_RISE) || (phase_ff == PH_FALL);

   // Next-state logic for the measurement state.
   always_comb begin
      logic [WIDE_BITS-1:0]    tick_w;
      logic [WIDE_BITS-1:0]    next_w;
      logic [WIDE_BITS-1:0]    span_w;
      logic [COUNTER_BITS-1:0] span_c;
      logic [7:0]              count_inc;

      phase_in     = phase_ff;
      tick_in      = tick_ff;
      rise_in      = rise_ff;
      width_in     = width_ff;
      last_echo_in = last_echo_ff;
      tstage_in    = tstage_ff;
      tcount_in    = tcount_ff;

      tick_w    = WIDE_BITS'(tick_ff);
      next_w    = '0;
      span_w    = '0;
      span_c    = '0;
      count_inc = tcount_ff + 8'd1;

      if (req_accept) begin
         if (req_payload.action) begin
            if (!busy) begin
               tick_in   = '0;
               rise_in   = '0;
               width_in  = '0;
               phase_in  = PH_RISE;
               tstage_in = TS_PRE;
               tcount_in = '0;
            end
         end else begin
            // Trigger sequencer.
            unique case (tstage_ff)
               TS_PRE: begin
                  tcount_in = count_inc;
                  if (count_inc >= PRE_TICKS) begin
                     tstage_in = (trig_width_ff == 8'd0) ? TS_OFF : TS_HIGH;
                     tcount_in = '0;
                  end
               end
               TS_HIGH: begin
                  tcount_in = count_inc;
                  if (count_inc >= trig_width_ff) begin
                     tstage_in = TS_OFF;
                     tcount_in = '0;
                  end
               end
               default: begin
                  tstage_in = TS_OFF;
                  tcount_in = '0;
               end
            endcase

            // Free-running counter with auto-reload.
            if (tick_w >= WIDE_BITS'(top_ff)) begin
               tick_in = '0;
            end else begin
               tick_in = tick_ff + COUNTER_BITS'(1);
            end
            next_w = WIDE_BITS'(tick_in);

            // Elapsed ticks since the rising edge, allowing for one wrap.
            if (next_w >= WIDE_BITS'(rise_ff)) begin
               span_w = next_w - WIDE_BITS'(rise_ff);
            end else begin
               span_w = WIDE_BITS'(top_ff) + WIDE_BITS'(1) + next_w
                        - WIDE_BITS'(rise_ff);
            end
            span_c = span_w[COUNTER_BITS-1:0];

            // Edge detection; a rising and a falling edge exclude each other.
            if (req_payload.echo_level && !last_echo_ff && phase_ff == PH_RISE) begin
               rise_in  = 16'(next_w);
               phase_in = PH_FALL;
            end else if (!req_payload.echo_level && last_echo_ff && phase_ff == PH_FALL) begin
               width_in = 16'(WIDE_BITS'(span_c));
               phase_in = PH_DONE;
            end
            last_echo_in = req_payload.echo_level;

            // Timeout check comes after the edge check.
            if ((phase_in == PH_RISE || phase_in == PH_FALL) &&
                next_w >= WIDE_BITS'(timeout_ff)) begin
               phase_in = PH_TOUT;
            end
         end
      end
   end

   // Result of the accepted request: phase and width from the updated state, trigger from the stage before it.
   always_comb begin
      a_meas_in.trigger_out   = (tstage_ff == TS_HIGH);
      a_meas_in.start_refused = 1'b0;
      if (req_payload.action) begin
         if (busy) begin
            a_meas_in.start_refused = 1'b1;
         end else begin
            a_meas_in.trigger_out = 1'b0;
         end
      end
      a_meas_in.phase      = phase_in;
      a_meas_in.echo_ticks = (phase_in == PH_DONE) ? width_in : 16'd0;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         top_ff        <= TOP_RESET;
         trig_width_ff <= TRIG_WIDTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT:    timeout_ff    <= csr_wdata;
            CSR_TOP:        top_ff        <= csr_wdata;
            CSR_TRIG_WIDTH: trig_width_ff <= csr_wdata[7:0];
            default:        ;
         endcase
      end
   end

   // Measurement state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         rise_ff      <= '0;
         width_ff     <= '0;
         last_echo_ff <= 1'b0;
         tstage_ff    <= TS_OFF;
         tcount_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         rise_ff      <= rise_in;
         width_ff     <= width_in;
         last_echo_ff <= last_echo_in;
         tstage_ff    <= tstage_in;
         tcount_ff    <= tcount_in;
      end
   end

   // First pipeline stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_accept) begin
         a_valid_ff <= 1'b1;
      end else if (b_load) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_meas_ff <= a_meas_in;
      end
   end

   // Distance conversion between the two stages.
   uerc_distance u_distance (
      .echo_ticks  (a_meas_ff.echo_ticks),
      .distance_mm (conv_mm),
      .distance_cm (conv_cm)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         rsp_payload_ff.trigger_out   <= a_meas_ff.trigger_out;
         rsp_payload_ff.phase         <= a_meas_ff.phase;
         rsp_payload_ff.start_refused <= a_meas_ff.start_refused;
         rsp_payload_ff.echo_ticks    <= a_meas_ff.echo_ticks;
         rsp_payload_ff.distance_mm   <= conv_mm;
         rsp_payload_ff.distance_cm   <= conv_cm;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire
